/* rtl/core/aabb_pkg.sv */
package aabb_pkg;

  localparam int CoordW = 32;
  localparam int HalfW  = 24;
  localparam int DistW  = 16;
  localparam int FaceW  = CoordW + 2;
  localparam int SqW    = 2 * DistW + 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_START_IN = 2'd1,
    ST_END_OUT  = 2'd2
  } status_t;

  localparam logic [0:0] REG_OBST_HALF = 1'b0;
  localparam logic [0:0] REG_CONTACT   = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [HalfW-1:0] x;
    logic [HalfW-1:0] y;
    logic [HalfW-1:0] z;
  } half_t;

  // Bisection working state carried through every stage.
  typedef struct packed {
    vec_t    lo;
    vec_t    hi;
    half_t   mh;
    vec_t    ob;
    logic    done;
    status_t status;
  } work_t;

  // Closed overlap test on one axis; faces in FaceW bits never wrap.
  function automatic logic axis_hit(input logic signed [CoordW-1:0] a,
                                    input logic [HalfW-1:0] ah,
                                    input logic signed [CoordW-1:0] b,
                                    input logic [HalfW-1:0] bh);
    logic signed [FaceW-1:0] amax, amin, bmax, bmin;
    begin
      amax = FaceW'(a) + $signed({2'b0, {(CoordW-HalfW){1'b0}}, ah});
      amin = FaceW'(a) - $signed({2'b0, {(CoordW-HalfW){1'b0}}, ah});
      bmax = FaceW'(b) + $signed({2'b0, {(CoordW-HalfW){1'b0}}, bh});
      bmin = FaceW'(b) - $signed({2'b0, {(CoordW-HalfW){1'b0}}, bh});
      axis_hit = (amax >= bmin) && (amin <= bmax);
    end
  endfunction

  function automatic logic box_hit(input vec_t p, input half_t mh, input vec_t ob,
                                   input logic [HalfW-1:0] oh);
    box_hit = axis_hit(p.x, mh.x, ob.x, oh) && axis_hit(p.y, mh.y, ob.y, oh)
           && axis_hit(p.z, mh.z, ob.z, oh);
  endfunction

  // floor((a+b)/2) exactly.
  function automatic logic signed [CoordW-1:0] half_sum(
      input logic signed [CoordW-1:0] a, input logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] s;
    begin
      s = (CoordW+1)'(a) + (CoordW+1)'(b);
      half_sum = s[CoordW:1];
    end
  endfunction

  // Absolute gap of one axis, saturated flag when not below 2^DistW.
  function automatic logic [DistW:0] gap(input logic signed [CoordW-1:0] lo,
                                         input logic signed [CoordW-1:0] hi);
    logic signed [CoordW:0] d;
    logic [CoordW:0] m;
    begin
      d = (CoordW+1)'(hi) - (CoordW+1)'(lo);
      m = d[CoordW] ? (CoordW+1)'(-d) : (CoordW+1)'(d);
      gap = (m[CoordW:DistW] != '0) ? {1'b1, {DistW{1'b0}}} : {1'b0, m[DistW-1:0]};
    end
  endfunction

endpackage

/* rtl/core/aabb_step.sv */
// One bisection step: distance test, midpoint, overlap test, bracket update.
// The squares of the axis gaps are registered before the sum and compare.
module aabb_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  aabb_pkg::work_t       in_work,
  input  logic [aabb_pkg::HalfW-1:0] oh,
  input  logic [aabb_pkg::SqW-1:0]   lim,
  output logic                  out_valid,
  output aabb_pkg::work_t       out_work
);
  import aabb_pkg::*;

  logic            a_valid;
  work_t           a_work;
  logic            a_far_big;
  logic [2*DistW-1:0] a_sq [3];
  logic [DistW:0]  gx, gy, gz;
  logic            far;
  logic [SqW-1:0]  sum;
  vec_t            mid;
  work_t           nxt;

  always_comb begin
    gx = gap(in_work.lo.x, in_work.hi.x);
    gy = gap(in_work.lo.y, in_work.hi.y);
    gz = gap(in_work.lo.z, in_work.hi.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      out_valid <= a_valid;
    end
    if (adv) begin
      a_work <= in_work;
      a_far_big <= gx[DistW] | gy[DistW] | gz[DistW];
      a_sq[0] <= gx[DistW-1:0] * gx[DistW-1:0];
      a_sq[1] <= gy[DistW-1:0] * gy[DistW-1:0];
      a_sq[2] <= gz[DistW-1:0] * gz[DistW-1:0];
      out_work <= nxt;
    end
  end

  always_comb begin
    sum = SqW'(a_sq[0]) + SqW'(a_sq[1]) + SqW'(a_sq[2]);
    far = a_far_big || (sum >= lim);
    mid.x = half_sum(a_work.lo.x, a_work.hi.x);
    mid.y = half_sum(a_work.lo.y, a_work.hi.y);
    mid.z = half_sum(a_work.lo.z, a_work.hi.z);
    nxt = a_work;
    if (!a_work.done) begin
      if (!far) begin
        nxt.done = 1'b1;
      end else if (box_hit(mid, a_work.mh, a_work.ob, oh)) begin
        nxt.hi = mid;
      end else begin
        nxt.lo = mid;
      end
    end
  end

endmodule

/* rtl/core/aabb_contact_bisection.sv */
// Channel   | direction | handshake          | payload
// in        | input     | in_valid/in_stall  | start_*, end_*, mover_half_*, obstacle_*
// out       | output    | out_valid/out_stall| safe_x, safe_y, safe_z, status
// cfg       | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The pipeline is one entry stage with both end-point overlap tests, MAX_STEPS
// two-register bisection steps, and the output register. A new item can enter
// in every cycle without an out stall, so throughput is one per cycle.
// Reset is synchronous: valid bits clear, config registers return to defaults.
// Out stall freezes the whole pipe; nothing is lost or repeated.
module aabb_contact_bisection #(
  parameter int MAX_STEPS = 48
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic [23:0] mover_half_x,
  input  logic [23:0] mover_half_y,
  input  logic [23:0] mover_half_z,
  input  logic signed [31:0] obstacle_x,
  input  logic signed [31:0] obstacle_y,
  input  logic signed [31:0] obstacle_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] safe_x,
  output logic signed [31:0] safe_y,
  output logic signed [31:0] safe_z,
  output logic [1:0] status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [23:0] cfg_data
);
  import aabb_pkg::*;

  logic [HalfW-1:0] obst_half;
  logic [DistW-1:0] contact;
  logic [SqW-1:0]   lim;
  logic             adv;
  logic             s0_valid;
  work_t            s0_work;
  work_t            ent;
  vec_t             st, en, ob;
  half_t            mh;
  logic             v [MAX_STEPS+1];
  work_t            w [MAX_STEPS+1];

  // Any stage may advance only when the output is free to move.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obst_half <= HalfW'(32768);
      contact <= DistW'(66);
      lim <= SqW'(66 * 66);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OBST_HALF: obst_half <= cfg_data;
        REG_CONTACT: begin
          contact <= cfg_data[DistW-1:0];
          lim <= SqW'((2*DistW)'(cfg_data[DistW-1:0]) * (2*DistW)'(cfg_data[DistW-1:0]));
        end
        default: ;
      endcase
    end
  end

  // Entry stage: test both end points, settle the special cases early.
  always_comb begin
    st = '{start_x, start_y, start_z};
    en = '{end_x, end_y, end_z};
    ob = '{obstacle_x, obstacle_y, obstacle_z};
    mh = '{mover_half_x, mover_half_y, mover_half_z};
    ent.lo = st;
    ent.hi = en;
    ent.mh = mh;
    ent.ob = ob;
    ent.done = 1'b0;
    ent.status = ST_OK;
    if (box_hit(st, mh, ob, obst_half)) begin
      ent.done = 1'b1;
      ent.status = ST_START_IN;
    end else if (!box_hit(en, mh, ob, obst_half)) begin
      ent.done = 1'b1;
      ent.status = ST_END_OUT;
      ent.lo = en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
    if (adv) begin
      s0_work <= ent;
    end
  end

  assign v[0] = s0_valid;
  assign w[0] = s0_work;

  for (genvar g = 0; g < MAX_STEPS; g++) begin : g_step
    aabb_step u_step (
      .clk(clk), .rst(rst), .adv(adv),
      .in_valid(v[g]), .in_work(w[g]),
      .oh(obst_half), .lim(lim),
      .out_valid(v[g+1]), .out_work(w[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[MAX_STEPS];
    end
    if (adv) begin
      safe_x <= w[MAX_STEPS].lo.x;
      safe_y <= w[MAX_STEPS].lo.y;
      safe_z <= w[MAX_STEPS].lo.z;
      status <= w[MAX_STEPS].status;
    end
  end

  // Special cases leave the entry stage finished.
  a_spec_done: assert property (@(posedge clk) disable iff (rst)
    s0_valid && s0_work.status != ST_OK |-> s0_work.done)
    else $error("special status not marked done");
  // Status 3 never comes out.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(safe_x) && $stable(status))
    else $error("stalled result changed");
  // Contact limit matches the contact register.
  a_lim: assert property (@(posedge clk) disable iff (rst)
    lim == SqW'((2*DistW)'(contact) * (2*DistW)'(contact)))
    else $error("limit out of step");

endmodule

/* tb/tb.sv */
module tb;
  import aabb_pkg::*;

  localparam int LATENCY = 2 * 48 + 2;
  localparam int STEP_LIMIT = 48;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [23:0] hx, hy, hz;
    logic signed [31:0] ox, oy, oz;
  } query_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    status_t st;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
  logic [23:0] mover_half_x = '0, mover_half_y = '0, mover_half_z = '0;
  logic signed [31:0] obstacle_x = '0, obstacle_y = '0, obstacle_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] safe_x, safe_y, safe_z;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = REG_OBST_HALF;
  logic [23:0] cfg_data = '0;

  aabb_contact_bisection dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copies of the two registers, used by the predictor.
  logic [23:0] cube_half;
  logic [15:0] stop_dist;

  query_t   pending_queries[$];
  contact_t expected_contacts[$];
  int errors = 0;
  int queries_sent = 0, contacts_seen = 0;
  int status_count[3] = '{0, 0, 0};
  bit calm_phase = 1'b0;  // long stretch with no idling
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  function automatic bit axis_touch(longint a, longint ah, longint b, longint bh);
    return (a + ah >= b - bh) && (a - ah <= b + bh);
  endfunction

  function automatic bit box_touch(longint p[3], longint mh[3], longint ob[3], longint oh);
    for (int i = 0; i < 3; i++)
      if (!axis_touch(p[i], mh[i], ob[i], oh)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit bracket_far(longint lo[3], longint hi[3]);
    longint unsigned total, lim, m;
    total = 0;
    lim = longint'(stop_dist) * longint'(stop_dist);
    for (int i = 0; i < 3; i++) begin
      m = (hi[i] >= lo[i]) ? hi[i] - lo[i] : lo[i] - hi[i];
      if (m >= 65536) return 1'b1;
      total += m * m;
    end
    return total >= lim;
  endfunction

  // Flag an inside start or a clear end, else bisect the swept segment down to the last point clear of the cube.
  function automatic contact_t find_contact(query_t q);
    longint lo[3], hi[3], mh[3], ob[3], mid[3];
    contact_t r;
    int steps;
    lo = '{q.sx, q.sy, q.sz};
    hi = '{q.ex, q.ey, q.ez};
    mh = '{longint'(q.hx), longint'(q.hy), longint'(q.hz)};
    ob = '{q.ox, q.oy, q.oz};
    r.st = ST_OK;
    if (box_touch(lo, mh, ob, cube_half)) begin
      r.st = ST_START_IN;
    end else if (!box_touch(hi, mh, ob, cube_half)) begin
      r.st = ST_END_OUT;
      lo = hi;
    end else begin
      steps = 0;
      while (steps < STEP_LIMIT && bracket_far(lo, hi)) begin
        for (int i = 0; i < 3; i++) mid[i] = (lo[i] + hi[i]) >>> 1;
        if (box_touch(mid, mh, ob, cube_half)) hi = mid;
        else lo = mid;
        steps++;
      end
    end
    r.x = lo[0][31:0];
    r.y = lo[1][31:0];
    r.z = lo[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 30)
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
               contacts_seen);
  endtask

  // Driver: hold a stalled transfer, advance on acceptance, idle at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) queries_sent++;
      if (!(in_valid && in_stall)) begin
        if (pending_queries.size() > 0 && (calm_phase || $urandom_range(99) >= 14)) begin
          query_t q;
          q = pending_queries.pop_front();
          expected_contacts.push_back(find_contact(q));
          in_valid <= 1'b1;
          start_x <= q.sx; start_y <= q.sy; start_z <= q.sz;
          end_x <= q.ex; end_y <= q.ey; end_z <= q.ez;
          mover_half_x <= q.hx; mover_half_y <= q.hy; mover_half_z <= q.hz;
          obstacle_x <= q.ox; obstacle_y <= q.oy; obstacle_z <= q.oz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the output at random, compare each transfer out against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      out_stall <= calm_phase ? 1'b0 : ($urandom_range(99) < 14);
      if (out_valid && !out_stall) begin
        contacts_seen++;
        if (expected_contacts.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          contact_t e;
          e = expected_contacts.pop_front();
          if (safe_x !== e.x) report_mismatch("safe_x", safe_x, e.x);
          if (safe_y !== e.y) report_mismatch("safe_y", safe_y, e.y);
          if (safe_z !== e.z) report_mismatch("safe_z", safe_z, e.z);
          if (status !== e.st) report_mismatch("status", status, e.st);
          if (e.st <= ST_END_OUT) status_count[e.st]++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_contacts.size());
      $display("tb failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(65536 * 40)) - 65536 * 20;
    endcase
  endfunction

  function automatic logic [23:0] rand_half();
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'hffffff : 24'h0;
      default: return 24'($urandom_range(65536 * 2));
    endcase
  endfunction

  // Swept query that usually starts clear of the cube and ends inside it.
  function automatic query_t sweep_query();
    query_t q;
    q.ox = rand_coord(); q.oy = rand_coord(); q.oz = rand_coord();
    q.hx = rand_half(); q.hy = rand_half(); q.hz = rand_half();
    if ($urandom_range(9) < 7) begin
      q.ex = q.ox + $signed($urandom_range(65536)) - 32768;
      q.ey = q.oy + $signed($urandom_range(65536)) - 32768;
      q.ez = q.oz + $signed($urandom_range(65536)) - 32768;
      q.sx = q.ox + $signed($urandom_range(65536 * 64)) - 65536 * 32;
      q.sy = q.oy + $signed($urandom_range(65536 * 64)) - 65536 * 32;
      q.sz = q.oz + $signed($urandom_range(65536 * 64)) - 65536 * 32;
      if ($urandom_range(3) == 0) begin
        q.hx = 24'($urandom_range(65536)); q.hy = 24'($urandom_range(65536));
        q.hz = 24'($urandom_range(65536));
      end
    end else begin
      q.sx = rand_coord(); q.sy = rand_coord(); q.sz = rand_coord();
      q.ex = rand_coord(); q.ey = rand_coord(); q.ez = rand_coord();
    end
    return q;
  endfunction

  function automatic query_t make_query(logic [31:0] sx, logic [31:0] ex, logic [23:0] h,
                                        logic [31:0] o);
    query_t q;
    q.sx = sx; q.sy = 0; q.sz = 0;
    q.ex = ex; q.ey = 0; q.ez = 0;
    q.hx = h; q.hy = h; q.hz = h;
    q.ox = o; q.oy = 0; q.oz = 0;
    return q;
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OBST_HALF) cube_half = val;
    else stop_dist = val[15:0];
  endtask

  // Drain everything in flight, then let the pipe settle.
  task automatic drain();
    while (pending_queries.size() > 0 || expected_contacts.size() > 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    int phase_items;
    cube_half = 24'd32768;
    stop_dist = 16'd66;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: default registers, overlap cases, extremes, flat boxes.
    pending_queries.push_back(make_query(-5 * 65536, 0, 24'd32768, 0));
    pending_queries.push_back(make_query(0, 5 * 65536, 24'd32768, 0));
    pending_queries.push_back(make_query(-5 * 65536, -4 * 65536, 24'd32768, 0));
    pending_queries.push_back(make_query(-5 * 65536, 0, 24'd0, 0));
    pending_queries.push_back(make_query(32'h80000000, 32'h7fffffff, 24'hffffff, 0));
    pending_queries.push_back(make_query(32'h80000000, 32'h7fffffff, 24'd0, 32'h7fffffff));
    pending_queries.push_back(make_query(32'h7fffffff, 32'h80000000, 24'hffffff,
                                         32'h80000000));
    pending_queries.push_back(make_query(-65536, -65535, 24'd32768, 0));
    pending_queries.push_back(make_query(-65536, 0, 24'd0, 0));
    pending_queries.push_back(make_query(32'hffffffff, 32'hffffffff, 24'hffffff,
                                         32'hffffffff));
    for (int i = 0; i < 6; i++) pending_queries.push_back(sweep_query());
    drain();

    write_reg(REG_CONTACT, 24'd0);
    pending_queries.push_back(make_query(-5 * 65536, 0, 24'd32768, 0));
    pending_queries.push_back(make_query(32'h80000000, 32'h7fffffff, 24'hffffff, 0));
    drain();
    write_reg(REG_OBST_HALF, 24'hffffff);
    write_reg(REG_CONTACT, 24'hffff);
    pending_queries.push_back(make_query(32'h80000000, 32'h7fffffff, 24'd0, 0));
    pending_queries.push_back(sweep_query());
    drain();

    // Random phases across register settings; the sender pauses at each drain.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin write_reg(REG_OBST_HALF, 24'd32768); write_reg(REG_CONTACT, 24'd66); end
        1: begin write_reg(REG_OBST_HALF, 24'd1); write_reg(REG_CONTACT, 24'd1); end
        2: begin write_reg(REG_OBST_HALF, 24'hffffff); write_reg(REG_CONTACT, 24'hffff); end
        3: calm_phase = 1'b1;
        4: begin
          calm_phase = 1'b0;
          write_reg(REG_OBST_HALF, 24'($urandom_range(1, 24'hffffff)));
          write_reg(REG_CONTACT, 24'($urandom_range(1, 16'hffff)));
        end
        default: begin write_reg(REG_OBST_HALF, 24'd65536); write_reg(REG_CONTACT, 24'd0); end
      endcase
      phase_items = 120;
      for (int i = 0; i < phase_items; i++) pending_queries.push_back(sweep_query());
      drain();
    end
    calm_phase = 1'b0;

    $display("sent %0d swept queries, checked %0d results", queries_sent, contacts_seen);
    $display("status mix: ok %0d, start inside %0d, end clear %0d",
             status_count[0], status_count[1], status_count[2]);
    if (errors == 0 && expected_contacts.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/aabb_pkg.sv
rtl/core/aabb_step.sv
rtl/core/aabb_contact_bisection.sv
tb/tb.sv
